// File: rtl/aist_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive idle-suspend timer package
// Codes, widths and fixed-point constants shared by the timer RTL.
// ----------------------------------------------------------------------------
package aist_pkg;

   // transaction kind carried on req_tuser
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   // context modes carried on req_tdata
   localparam logic [1:0] MODE_ENERGY   = 2'd0;
   localparam logic [1:0] MODE_BALANCED = 2'd1;
   localparam logic [1:0] MODE_LATENCY  = 2'd2;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_ENERGY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_BALANCED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_LATENCY  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE        = 2'd3;

   // Q1.8 weights and Q24.8 values
   localparam int unsigned WEIGHT_W = 9;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned PROD_W   = VALUE_W + WEIGHT_W;
   localparam int unsigned ACC_W    = 42;

   localparam logic [WEIGHT_W-1:0] ALPHA_ONE        = 9'd256;
   localparam logic [WEIGHT_W-1:0] AVG_KEEP         = 9'd230;
   localparam logic [WEIGHT_W-1:0] AVG_NEW          = 9'd26;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ENERGY_RST   = 9'd205;
   localparam logic [WEIGHT_W-1:0] WEIGHT_BALANCED_RST = 9'd128;
   localparam logic [WEIGHT_W-1:0] WEIGHT_LATENCY_RST  = 9'd51;
   localparam logic [VALUE_W-1:0]  TIMEOUT_RST      = 32'd5000 << 8;
   localparam logic [ACC_W-1:0]    ROUND_HALF       = 42'd128;

   // stream widths
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 56;

endpackage

// File: rtl/adaptive_idle_suspend_timer_unit.sv
// ----------------------------------------------------------------------------
// Adaptive idle-suspend timer
// Saturating idle counter with suspend/resume and an adaptive Q24.8 timeout
// blended per context mode, computed on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel | dir | ports                            | contents
//  req     | in  | req_tvalid/tready/tdata/tuser    | tick or activity event
//  rsp     | out | rsp_tvalid/tready/tdata          | status after each item
//  csr     | in  | csr_we/csr_index/csr_wdata       | weights, baseline
//
//  A tick passes ST_TICK and ST_DONE, an event while awake ST_TO0, ST_TO1,
//  ST_TO_WR and ST_DONE, and an event that resumes ST_AVG0, ST_AVG1 and
//  ST_AVG_WR first; the steps are set by the 32x9 multiplier that the
//  sequencer reuses for the average and the timeout blend, one product a cycle.
//  req_tready is high only in the idle state; a new transaction may be taken
//  while the last result still waits on rsp, the next result then holds.
//  Reset is synchronous and active high.
// ----------------------------------------------------------------------------
module adaptive_idle_suspend_timer_unit
   import aist_pkg::*;
#(
   parameter int IDLE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [1:0] context_mode
   input  logic                  req_tuser,   // [0] operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] suspended, [1] suspend_now,
                                              // [2] resume_now, [26:3] timeout_ms,
                                              // [50:27] idle_average_ms
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CMP_W = (IDLE_BITS + 8 > VALUE_W) ? IDLE_BITS + 8 : VALUE_W;
   localparam logic [IDLE_BITS-1:0] IDLE_MAX = {IDLE_BITS{1'b1}};

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_TICK   = 4'd1;
   localparam logic [3:0] ST_AVG0   = 4'd2;
   localparam logic [3:0] ST_AVG1   = 4'd3;
   localparam logic [3:0] ST_AVG_WR = 4'd4;
   localparam logic [3:0] ST_TO0    = 4'd5;
   localparam logic [3:0] ST_TO1    = 4'd6;
   localparam logic [3:0] ST_TO_WR  = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [1:0]            mode_ff, mode_in;
   logic [IDLE_BITS-1:0]  idle_ff, idle_in;
   logic [VALUE_W-1:0]    timeout_ff, timeout_in;
   logic [VALUE_W-1:0]    avg_ff, avg_in;
   logic                  asleep_ff, asleep_in;
   logic                  susp_now_ff, susp_now_in;
   logic                  res_now_ff, res_now_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [WEIGHT_W-1:0]   w_energy_ff, w_energy_in;
   logic [WEIGHT_W-1:0]   w_balanced_ff, w_balanced_in;
   logic [WEIGHT_W-1:0]   w_latency_ff, w_latency_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [WEIGHT_W-1:0]   alpha_raw, alpha;
   logic [IDLE_BITS-1:0]  idle_inc;
   logic                  reach_timeout;
   logic [VALUE_W-1:0]    mul_a;
   logic [WEIGHT_W-1:0]   mul_b;
   logic [PROD_W-1:0]     product;
   logic [ACC_W-1:0]      acc_base;
   logic [ACC_W-1:0]      acc_sum;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      case (mode_ff)
         MODE_ENERGY:  alpha_raw = w_energy_ff;
         MODE_LATENCY: alpha_raw = w_latency_ff;
         default:      alpha_raw = w_balanced_ff;
      endcase
      alpha = (alpha_raw > ALPHA_ONE) ? ALPHA_ONE : alpha_raw;
   end

   assign idle_inc      = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 1'b1;
   assign reach_timeout = CMP_W'({idle_inc, 8'h00}) >= CMP_W'(timeout_ff);

   // shared multiply-accumulate unit
   assign product = {{WEIGHT_W{1'b0}}, mul_a} * {{VALUE_W{1'b0}}, mul_b};
   assign acc_sum = ACC_W'(product) + acc_base;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      idle_in       = idle_ff;
      timeout_in    = timeout_ff;
      avg_in        = avg_ff;
      asleep_in     = asleep_ff;
      susp_now_in   = susp_now_ff;
      res_now_in    = res_now_ff;
      acc_in        = acc_ff;
      w_energy_in   = w_energy_ff;
      w_balanced_in = w_balanced_ff;
      w_latency_in  = w_latency_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mul_a         = avg_ff;
      mul_b         = AVG_KEEP;
      acc_base      = ROUND_HALF;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in     = req_tdata[1:0];
               susp_now_in = 1'b0;
               res_now_in  = 1'b0;
               if (req_tuser == OP_TICK) begin
                  state_in = ST_TICK;
               end else if (asleep_ff) begin
                  state_in = ST_AVG0;
               end else begin
                  state_in = ST_TO0;
               end
            end
         end
         ST_TICK: begin
            idle_in = idle_inc;
            if (!asleep_ff && reach_timeout) begin
               asleep_in   = 1'b1;
               susp_now_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_AVG0: begin
            mul_a    = avg_ff;
            mul_b    = AVG_KEEP;
            acc_base = ROUND_HALF;
            acc_in   = acc_sum;
            state_in = ST_AVG1;
         end
         ST_AVG1: begin
            // new sample is idle << 8, so it adds after the round-and-shift
            mul_a    = VALUE_W'(idle_ff);
            mul_b    = AVG_NEW;
            acc_base = ACC_W'(acc_ff[ACC_W-1:8]);
            acc_in   = acc_sum;
            state_in = ST_AVG_WR;
         end
         ST_AVG_WR: begin
            avg_in     = (|acc_ff[ACC_W-1:VALUE_W]) ? {VALUE_W{1'b1}} : acc_ff[VALUE_W-1:0];
            asleep_in  = 1'b0;
            res_now_in = 1'b1;
            state_in   = ST_TO0;
         end
         ST_TO0: begin
            mul_a    = timeout_ff;
            mul_b    = alpha;
            acc_base = ROUND_HALF;
            acc_in   = acc_sum;
            idle_in  = '0;
            state_in = ST_TO1;
         end
         ST_TO1: begin
            mul_a    = avg_ff;
            mul_b    = ALPHA_ONE - alpha;
            acc_base = acc_ff;
            acc_in   = acc_sum;
            state_in = ST_TO_WR;
         end
         ST_TO_WR: begin
            timeout_in = (|acc_ff[ACC_W-1:VALUE_W+8]) ? {VALUE_W{1'b1}}
                                                      : acc_ff[VALUE_W+7:8];
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, avg_ff[VALUE_W-1:8], timeout_ff[VALUE_W-1:8],
                               res_now_ff, susp_now_ff, asleep_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_WEIGHT_ENERGY:   w_energy_in   = csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT_BALANCED: w_balanced_in = csr_wdata[WEIGHT_W-1:0];
            CSR_WEIGHT_LATENCY:  w_latency_in  = csr_wdata[WEIGHT_W-1:0];
            CSR_BASELINE:        timeout_in    = {csr_wdata, 8'h00};
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idle_ff       <= '0;
         timeout_ff    <= TIMEOUT_RST;
         avg_ff        <= '0;
         asleep_ff     <= 1'b0;
         w_energy_ff   <= WEIGHT_ENERGY_RST;
         w_balanced_ff <= WEIGHT_BALANCED_RST;
         w_latency_ff  <= WEIGHT_LATENCY_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idle_ff       <= idle_in;
         timeout_ff    <= timeout_in;
         avg_ff        <= avg_in;
         asleep_ff     <= asleep_in;
         w_energy_ff   <= w_energy_in;
         w_balanced_ff <= w_balanced_in;
         w_latency_ff  <= w_latency_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      susp_now_ff <= susp_now_in;
      res_now_ff  <= res_now_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
